// ----- rtl/hall_sensor_direction_speed_defines.svh -----
// Assertion macros shared by the Hall decoder RTL.
`ifndef HALL_SENSOR_DIRECTION_SPEED_DEFINES_SVH
`define HALL_SENSOR_DIRECTION_SPEED_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hsds_pkg.sv -----
// Package with types, constants and wiring tables of the Hall decoder.
package hsds_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int SPEED_W  = 32;
    localparam int TICKS_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int NUM_W    = TICKS_W + FRAC_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(72000);
    localparam logic               REG_TICKS_PER_MS = 1'b0;

    localparam logic [SPEED_W-1:0] SPEED_MAX_POS = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MAX_NEG = {1'b1, {(SPEED_W-1){1'b0}}};

    typedef logic [2:0] hall_code_t;
    localparam hall_code_t HALL_INVALID = 3'd0;

    typedef enum logic [1:0] {
        DIR_UNKNOWN,
        DIR_FORWARD,
        DIR_REVERSE
    } dir_t;

    typedef enum logic [2:0] {
        OUT_INVALID,
        OUT_FIRST,
        OUT_FORWARD,
        OUT_REVERSE,
        OUT_OTHER
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0]        raw_hall;
        logic [TIME_W-1:0] timestamp;
    } hsds_in_t;

    typedef struct packed {
        logic [2:0]                hall_state;
        logic [1:0]                direction;
        logic [2:0]                outcome;
        logic signed [COUNT_W-1:0] pulse_total;
        logic signed [SPEED_W-1:0] speed;
    } hsds_out_t;

    // Status of the serial divider toward the controller.
    typedef struct packed {
        logic               done;
        logic               sat;
        logic [SPEED_W-1:0] quotient;
    } div_result_t;

    // Sensor wiring: raw code to Hall state, codes 0 and 7 are invalid.
    function automatic hall_code_t wire_remap(input logic [2:0] raw);
        hall_code_t code;
        unique case (raw)
            3'd1:    code = 3'd2;
            3'd2:    code = 3'd1;
            3'd3:    code = 3'd3;
            3'd4:    code = 3'd4;
            3'd5:    code = 3'd6;
            3'd6:    code = 3'd5;
            default: code = HALL_INVALID;
        endcase
        return code;
    endfunction

    // Next Hall state when the rotor turns forward.
    function automatic hall_code_t fwd_next(input hall_code_t s);
        hall_code_t n;
        unique case (s)
            3'd1:    n = 3'd3;
            3'd2:    n = 3'd6;
            3'd3:    n = 3'd2;
            3'd4:    n = 3'd5;
            3'd5:    n = 3'd1;
            3'd6:    n = 3'd4;
            default: n = HALL_INVALID;
        endcase
        return n;
    endfunction

    // Next Hall state when the rotor turns in reverse.
    function automatic hall_code_t rev_next(input hall_code_t s);
        hall_code_t n;
        unique case (s)
            3'd1:    n = 3'd5;
            3'd2:    n = 3'd3;
            3'd3:    n = 3'd1;
            3'd4:    n = 3'd6;
            3'd5:    n = 3'd4;
            3'd6:    n = 3'd2;
            default: n = HALL_INVALID;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/hsds_divider.sv -----
// Bit-serial restoring divider for the speed quotient, one quotient bit per cycle.
module hsds_divider
    import hsds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TICKS_W-1:0]  ticks,
    input  logic [TIME_W-1:0]   divisor,
    output div_result_t         result
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(NUM_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [TIME_W-1:0]   rem_reg, rem_next;
    logic [TIME_W-1:0]   div_reg, div_next;
    logic [SPEED_W-1:0]  quo_reg, quo_next;

    logic [TIME_W:0]     trial;
    logic [TIME_W:0]     trial_sub;
    logic                fits;

    // One restoring step: bring down the next numerator bit and try a subtract.
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            ovf_next  = 1'b0;
            cnt_next  = STEPS;
            num_next  = {ticks, {FRAC_W{1'b0}}};
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = fits ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], fits};
            // Any quotient bit pushed past the top means the result saturates.
            ovf_next = ovf_reg | quo_reg[SPEED_W-1];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign result.done     = done_reg;
    assign result.sat      = ovf_reg | quo_reg[SPEED_W-1];
    assign result.quotient = quo_reg;

endmodule

// ----- rtl/hall_sensor_direction_speed.sv -----
// Hall sensor decoder: a request is one Hall edge (raw sensor bits and a timestamp); the
// block remaps the bits, tracks the Hall state, direction and a signed step count, and on
// every forward or reverse step computes the speed in signed Q16.16 pulses per millisecond
// as ticks_per_ms * 65536 divided by the wrapped time since the last step or
// out-of-sequence edge, saturated, with a zero time difference giving the largest
// magnitude. Every request yields one result. A request that needs no division (invalid
// code, first state, out-of-sequence code, or a step with zero time difference) goes to
// the hold state, which loads its result into the output register once that register is
// free. A step with a division first runs the 40-step bit-serial restoring divider (24-bit
// ticks plus 16 fraction bits), then takes the speed and goes to the hold state. The next
// request can be taken after the load. One request is processed at a time; the next is
// accepted while a result waits in the output register, and a result that cannot be
// loaded because the receiver stalls holds the input stalled as well.
// ticks_per_ms resets to 72000 and sits at byte address 0 of the register port.
`include "hall_sensor_direction_speed_defines.svh"

module hall_sensor_direction_speed
    import hsds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                hall_valid,
    output logic                hall_stall,
    input  hsds_in_t            hall_data,

    output logic                result_valid,
    input  logic                result_stall,
    output hsds_out_t           result_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    ctrl_state_t         state_reg, state_next;
    logic [TICKS_W-1:0]  ticks_reg, ticks_next;
    hall_code_t          position_reg, position_next;
    dir_t                direction_reg, direction_next;
    outcome_t            outcome_reg, outcome_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic                out_valid_reg, out_valid_next;
    hsds_out_t           out_reg, out_next;

    logic                hall_accept;
    logic                out_free;
    logic                cfg_write;
    hall_code_t          code;
    logic                is_fwd;
    logic                is_rev;
    logic [TIME_W-1:0]   time_diff;
    logic                div_start;
    div_result_t         div_res;
    logic [SPEED_W-1:0]  div_speed;

    logic                chk_invalid;
    logic                chk_step;
    logic [COUNT_W+2:0]  track_bits;

    // Register port: single register, decoded on the word index bit.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign prdata    = (paddr[PADDR_W-1] == REG_TICKS_PER_MS)
                       ? PDATA_W'(ticks_reg) : '0;
    assign ticks_next = (cfg_write && paddr[PADDR_W-1] == REG_TICKS_PER_MS)
                        ? pwdata[TICKS_W-1:0] : ticks_reg;

    // Handshakes.
    assign hall_stall   = (state_reg != ST_IDLE);
    assign hall_accept  = hall_valid & ~hall_stall;
    assign out_free     = ~out_valid_reg | ~result_stall;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // Decode of the incoming edge against the current Hall state.
    assign code      = wire_remap(hall_data.raw_hall);
    assign is_fwd    = (code == fwd_next(position_reg));
    assign is_rev    = (code == rev_next(position_reg));
    assign time_diff = hall_data.timestamp - last_time_reg;

    // Saturate and sign the divider quotient for the stored direction.
    always_comb
    begin
        if (direction_reg == DIR_REVERSE)
        begin
            div_speed = div_res.sat ? SPEED_MAX_NEG : (SPEED_W'(0) - div_res.quotient);
        end
        else
        begin
            div_speed = div_res.sat ? SPEED_MAX_POS : div_res.quotient;
        end
    end

    // Controller: update tracking state, run the divider, hand the result over.
    always_comb
    begin
        state_next     = state_reg;
        position_next  = position_reg;
        direction_next = direction_reg;
        outcome_next   = outcome_reg;
        count_next     = count_reg;
        last_time_next = last_time_reg;
        speed_next     = speed_reg;
        out_valid_next = out_valid_reg & result_stall;
        out_next       = out_reg;
        div_start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (hall_accept)
                begin
                    state_next = ST_HOLD;
                    priority if (code == HALL_INVALID)
                    begin
                        outcome_next = OUT_INVALID;
                    end
                    else if (position_reg == HALL_INVALID)
                    begin
                        position_next = code;
                        outcome_next  = OUT_FIRST;
                    end
                    else if (is_fwd || is_rev)
                    begin
                        position_next  = code;
                        last_time_next = hall_data.timestamp;
                        direction_next = is_fwd ? DIR_FORWARD : DIR_REVERSE;
                        outcome_next   = is_fwd ? OUT_FORWARD : OUT_REVERSE;
                        count_next     = is_fwd ? count_reg + COUNT_W'(1)
                                                : count_reg - COUNT_W'(1);
                        if (time_diff == '0)
                        begin
                            speed_next = is_fwd ? SPEED_MAX_POS : SPEED_MAX_NEG;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIVIDE;
                        end
                    end
                    else
                    begin
                        last_time_next = hall_data.timestamp;
                        outcome_next   = OUT_OTHER;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_res.done)
                begin
                    speed_next = div_speed;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.hall_state  = position_reg;
                    out_next.direction   = direction_reg;
                    out_next.outcome     = outcome_reg;
                    out_next.pulse_total = count_reg;
                    out_next.speed       = speed_reg;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and tracking registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ticks_reg     <= TICKS_RESET;
            position_reg  <= HALL_INVALID;
            direction_reg <= DIR_UNKNOWN;
            outcome_reg   <= OUT_INVALID;
            count_reg     <= '0;
            last_time_reg <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ticks_reg     <= ticks_next;
            position_reg  <= position_next;
            direction_reg <= direction_next;
            outcome_reg   <= outcome_next;
            count_reg     <= count_next;
            last_time_reg <= last_time_next;
            speed_reg     <= speed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    hsds_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .ticks   (ticks_reg),
        .divisor (time_diff),
        .result  (div_res)
    );

    // Conditions watched by the checks below.
    assign chk_invalid = hall_accept && (code == HALL_INVALID);
    assign chk_step    = hall_accept && (position_reg != HALL_INVALID) && (is_fwd || is_rev);
    assign track_bits  = {position_reg, count_reg};

    // Checks on the controller.
    `HSDS_ASSERT_SAME(a_done_in_divide, div_res.done, state_reg == ST_DIVIDE, "stray done")
    `HSDS_ASSERT_NEXT(a_invalid_keeps_state, chk_invalid, $stable(track_bits), "invalid moved")
    `HSDS_ASSERT_SAME(a_count_on_request, $changed(count_reg), $past(hall_accept), "stray count")
    `HSDS_ASSERT_NEXT(a_step_sets_dir, chk_step, direction_reg != DIR_UNKNOWN, "no direction")

endmodule
